/* src/esc_pulse_ramp_sequencer_macros.svh */
// assertion macros used by the esc pulse ramp sequencer rtl
`ifndef ESC_PULSE_RAMP_SEQUENCER_MACROS_SVH
`define ESC_PULSE_RAMP_SEQUENCER_MACROS_SVH

// same-cycle implication
`define EPRS_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EPRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/esc_prs_pkg.sv */
// types, constants and helpers for the esc pulse ramp sequencer
`timescale 1ns / 1ps
`default_nettype none

package esc_prs_pkg;

	localparam int unsigned PW_W       = 12;
	localparam int unsigned STEP_W     = 10;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned SPEED_W    = 12;
	localparam int unsigned REQ_W      = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [REQ_W-1:0] req_t;

	localparam req_t REQ_FWD  = 2'd0;
	localparam req_t REQ_STOP = 2'd1;
	localparam req_t REQ_BACK = 2'd2;
	localparam req_t REQ_TICK = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FWD_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd6;

	localparam logic [STEP_W-1:0] RST_RAMP_STEP = 10'd20;
	localparam logic [PW_W-1:0]   RST_NEUTRAL   = 12'd1500;
	localparam logic [PW_W-1:0]   RST_FWD_MIN   = 12'd1300;
	localparam logic [PW_W-1:0]   RST_FWD_MAX   = 12'd1700;
	localparam logic [PW_W-1:0]   RST_FLOOR     = 12'd1000;
	localparam logic [PW_W-1:0]   RST_CEILING   = 12'd2000;
	localparam logic [HOLD_W-1:0] RST_HOLD      = 16'd50;

	localparam logic [9:0]  SPEED_MAX = 10'd1000;
	localparam logic [10:0] SPEED_OFS = 11'd1000;
	localparam logic signed [13:0] BRAKE_OFS = 14'sd50;

	// x / 125 == (x * DIV_RECIP) >> DIV_SHIFT, exact for x below 6.1e6
	localparam logic [19:0] DIV_RECIP = 20'd536871;
	localparam int unsigned DIV_SHIFT = 26;

	typedef struct packed {
		logic [STEP_W-1:0] ramp_step;
		logic [PW_W-1:0]   neutral;
		logic [PW_W-1:0]   fwd_min;
		logic [PW_W-1:0]   fwd_max;
		logic [PW_W-1:0]   floor_pw;
		logic [PW_W-1:0]   ceil_pw;
		logic [HOLD_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		req_t            req;
		logic [PW_W-1:0] target;
	} tgt_word_t;

	// below lo gives lo, else above hi gives hi
	function automatic logic [PW_W-1:0] clamp_pulse(input logic signed [13:0] v,
		input logic [PW_W-1:0] lo, input logic [PW_W-1:0] hi);
		logic [PW_W-1:0] r;
		if (v < $signed({2'b00, lo})) begin
			r = lo;
		end else if (v > $signed({2'b00, hi})) begin
			r = hi;
		end else begin
			r = v[PW_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/esc_prs_cfg.sv */
// configuration register file
`timescale 1ns / 1ps
`default_nettype none

module esc_prs_cfg (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [esc_prs_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire  [esc_prs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output esc_prs_pkg::cfg_t                      cfg
);

	esc_prs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_step  <= esc_prs_pkg::RST_RAMP_STEP;
			cfg_q.neutral    <= esc_prs_pkg::RST_NEUTRAL;
			cfg_q.fwd_min    <= esc_prs_pkg::RST_FWD_MIN;
			cfg_q.fwd_max    <= esc_prs_pkg::RST_FWD_MAX;
			cfg_q.floor_pw   <= esc_prs_pkg::RST_FLOOR;
			cfg_q.ceil_pw    <= esc_prs_pkg::RST_CEILING;
			cfg_q.hold_ticks <= esc_prs_pkg::RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				esc_prs_pkg::CFG_RAMP_STEP: begin
					cfg_q.ramp_step <= cfg_wdata[esc_prs_pkg::STEP_W-1:0];
				end
				esc_prs_pkg::CFG_NEUTRAL: begin
					cfg_q.neutral <= cfg_wdata[esc_prs_pkg::PW_W-1:0];
				end
				esc_prs_pkg::CFG_FWD_MIN: begin
					cfg_q.fwd_min <= cfg_wdata[esc_prs_pkg::PW_W-1:0];
				end
				esc_prs_pkg::CFG_FWD_MAX: begin
					cfg_q.fwd_max <= cfg_wdata[esc_prs_pkg::PW_W-1:0];
				end
				esc_prs_pkg::CFG_FLOOR: begin
					cfg_q.floor_pw <= cfg_wdata[esc_prs_pkg::PW_W-1:0];
				end
				esc_prs_pkg::CFG_CEILING: begin
					cfg_q.ceil_pw <= cfg_wdata[esc_prs_pkg::PW_W-1:0];
				end
				esc_prs_pkg::CFG_HOLD: begin
					cfg_q.hold_ticks <= cfg_wdata[esc_prs_pkg::HOLD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* src/esc_prs_target.sv */
// speed to target pulse mapping, three pipeline stages
`timescale 1ns / 1ps
`default_nettype none

module esc_prs_target (
	input  wire                                        clk,
	input  wire                                        arst_n,
	input  esc_prs_pkg::cfg_t                          cfg,
	input  wire                                        in_valid,
	output logic                                       in_ready,
	input  esc_prs_pkg::req_t                          in_req,
	input  wire  signed [esc_prs_pkg::SPEED_W-1:0]     in_speed,
	output logic                                       out_valid,
	input  wire                                        out_ready,
	output esc_prs_pkg::tgt_word_t                     out_word
);

	logic                                   v_s1;
	esc_prs_pkg::req_t                      req_s1;
	logic signed [esc_prs_pkg::SPEED_W-1:0] speed_s1;
	logic                                   v_s2;
	esc_prs_pkg::req_t                      req_s2;
	logic signed [23:0]                     prod_s2;
	logic                                   v_s3;
	esc_prs_pkg::tgt_word_t                 word_s3;

	logic               s2_rdy;
	logic               s3_rdy;
	logic [9:0]         spd_sat;
	logic [10:0]        span;
	logic signed [12:0] diff;
	logic signed [24:0] prod_full;
	logic               neg;
	logic [23:0]        mag_w;
	logic [18:0]        x_div;
	logic [38:0]        q_full;
	logic [11:0]        quot;
	logic signed [13:0] q_signed;
	logic signed [13:0] tsum;
	logic [11:0]        target;

	assign s3_rdy   = !v_s3 || out_ready;
	assign s2_rdy   = !v_s2 || s3_rdy;
	assign in_ready = !v_s1 || s2_rdy;

	// stage 1: saturate speed, span * (max - min)
	always_comb begin
		if (speed_s1 < 0) begin
			spd_sat = '0;
		end else if (speed_s1 > $signed({2'b00, esc_prs_pkg::SPEED_MAX})) begin
			spd_sat = esc_prs_pkg::SPEED_MAX;
		end else begin
			spd_sat = speed_s1[9:0];
		end
		span      = {1'b0, spd_sat} + esc_prs_pkg::SPEED_OFS;
		diff      = $signed({1'b0, cfg.fwd_max}) - $signed({1'b0, cfg.fwd_min});
		prod_full = $signed({1'b0, span}) * diff;
	end

	// stage 2: divide by 2000 toward zero, add min, clamp to min..max
	always_comb begin
		neg      = prod_s2[23];
		mag_w    = neg ? (24'd0 - prod_s2) : prod_s2;
		x_div    = mag_w[22:4];
		q_full   = {20'd0, x_div} * {19'd0, esc_prs_pkg::DIV_RECIP};
		quot     = q_full[esc_prs_pkg::DIV_SHIFT+11:esc_prs_pkg::DIV_SHIFT];
		q_signed = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
		tsum     = $signed({2'b00, cfg.fwd_min}) + q_signed;
		target   = esc_prs_pkg::clamp_pulse(tsum, cfg.fwd_min, cfg.fwd_max);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (s2_rdy) begin
				v_s2 <= v_s1;
			end
			if (s3_rdy) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1   <= in_req;
			speed_s1 <= in_speed;
		end
		if (s2_rdy && v_s1) begin
			req_s2  <= req_s1;
			prod_s2 <= prod_full[23:0];
		end
		if (s3_rdy && v_s2) begin
			word_s3.req    <= req_s2;
			word_s3.target <= target;
		end
	end

	assign out_valid = v_s3;
	assign out_word  = word_s3;

endmodule

`default_nettype wire

/* src/esc_prs_seq.sv */
// held pulse, reverse entry sequencer and output register
`timescale 1ns / 1ps
`default_nettype none

`include "esc_pulse_ramp_sequencer_macros.svh"

module esc_prs_seq (
	input  wire                                clk,
	input  wire                                arst_n,
	input  esc_prs_pkg::cfg_t                  cfg,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  esc_prs_pkg::tgt_word_t             in_word,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [esc_prs_pkg::PW_W-1:0]       out_pulse,
	output logic                               out_busy,
	output logic                               out_accepted
);

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_NEUTRAL = 2'd1;
	localparam logic [1:0] PH_BRAKE   = 2'd2;
	localparam logic [1:0] PH_REENTRY = 2'd3;

	logic [esc_prs_pkg::PW_W-1:0]   held_q;
	logic [1:0]                     phase_q;
	logic [esc_prs_pkg::HOLD_W-1:0] cnt_q;
	logic                           out_valid_q;
	logic [esc_prs_pkg::PW_W-1:0]   out_pulse_q;
	logic                           out_busy_q;
	logic                           out_acc_q;

	logic                           load;
	logic [esc_prs_pkg::PW_W-1:0]   held_n;
	logic [1:0]                     phase_n;
	logic [esc_prs_pkg::HOLD_W-1:0] cnt_n;
	logic [esc_prs_pkg::HOLD_W-1:0] cnt_inc;
	logic                           acc;
	logic                           wr;
	logic signed [13:0]             wv;
	logic [12:0]                    up_sum;
	logic [12:0]                    up_next;
	logic [11:0]                    dn_base;
	logic [11:0]                    dn_next;

	assign in_ready = !out_valid_q || out_ready;
	assign load     = in_valid && in_ready;
	assign cnt_inc  = cnt_q + 1'b1;

	// ramp toward target, one step at most
	always_comb begin
		up_sum  = {1'b0, held_q} + {3'b000, cfg.ramp_step};
		up_next = (up_sum > {1'b0, in_word.target}) ? {1'b0, in_word.target} : up_sum;
		dn_base = (held_q > {2'b00, cfg.ramp_step}) ?
			(held_q - {2'b00, cfg.ramp_step}) : cfg.floor_pw;
		dn_next = (dn_base < in_word.target) ? in_word.target : dn_base;
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		acc     = 1'b1;
		wr      = 1'b0;
		wv      = '0;
		if (in_word.req == esc_prs_pkg::REQ_TICK) begin
			if (phase_q != PH_IDLE) begin
				cnt_n = cnt_inc;
				if (cnt_inc >= cfg.hold_ticks) begin
					cnt_n = '0;
					wr    = 1'b1;
					unique case (phase_q)
						PH_NEUTRAL: begin
							wv      = $signed({2'b00, cfg.fwd_min}) - esc_prs_pkg::BRAKE_OFS;
							phase_n = PH_BRAKE;
						end
						PH_BRAKE: begin
							wv      = $signed({2'b00, cfg.neutral});
							phase_n = PH_REENTRY;
						end
						PH_REENTRY: begin
							wv      = $signed({2'b00, cfg.fwd_min});
							phase_n = PH_IDLE;
						end
						PH_IDLE: begin
							wr = 1'b0;
						end
					endcase
				end
			end
		end else if (phase_q != PH_IDLE) begin
			acc = 1'b0;
		end else begin
			unique case (in_word.req)
				esc_prs_pkg::REQ_FWD: begin
					if (in_word.target > held_q) begin
						wr = 1'b1;
						wv = $signed({1'b0, up_next});
					end else if (in_word.target < held_q) begin
						wr = 1'b1;
						wv = $signed({2'b00, dn_next});
					end
				end
				esc_prs_pkg::REQ_STOP: begin
					wr = 1'b1;
					wv = $signed({2'b00, cfg.neutral});
				end
				esc_prs_pkg::REQ_BACK: begin
					wr      = 1'b1;
					wv      = $signed({2'b00, cfg.neutral});
					phase_n = PH_NEUTRAL;
					cnt_n   = '0;
				end
				esc_prs_pkg::REQ_TICK: begin
					acc = 1'b1;
				end
			endcase
		end
		held_n = wr ? esc_prs_pkg::clamp_pulse(wv, cfg.floor_pw, cfg.ceil_pw) : held_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= esc_prs_pkg::RST_NEUTRAL;
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				held_q  <= held_n;
				phase_q <= phase_n;
				cnt_q   <= cnt_n;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pulse_q <= held_n;
			out_busy_q  <= (phase_n != PH_IDLE);
			out_acc_q   <= acc;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pulse    = out_pulse_q;
	assign out_busy     = out_busy_q;
	assign out_accepted = out_acc_q;

	`EPRS_ASSERT(a_reject_only_busy, clk, arst_n, out_valid_q && !out_acc_q, out_busy_q,
		"rejected word while idle")
	`EPRS_ASSERT(a_idle_count_clear, clk, arst_n, phase_q == PH_IDLE, cnt_q == '0,
		"tick count left over while idle")
	`EPRS_ASSERT_NEXT(a_state_on_load, clk, arst_n, !load,
		$stable({held_q, phase_q, cnt_q}), "state moved without a word")
	`EPRS_ASSERT_NEXT(a_seq_entry, clk, arst_n, load && phase_q == PH_IDLE,
		phase_q == PH_IDLE || phase_q == PH_NEUTRAL, "sequence entered past its first phase")

endmodule

`default_nettype wire

/* src/esc_pulse_ramp_sequencer.sv */
// esc pulse ramp sequencer top level
//
//  channel    dir  tdata (low bit up)                      tuser       words
//  s_axis     in   speed[11:0] signed, 4'b0                 req_type    1 per cycle if ready
//  m_axis     out  pulse_width[11:0], sequence_busy,        -           1 per word in
//                  accepted, 2'b0
//  cfg        in   cfg_we, cfg_addr (register index), cfg_wdata
//
// an accepted word travels to m_axis through three mapping stages
// (speed saturate and multiply, divide by 2000 and clamp, target register) then
// the state update into the output register; one word per cycle when not stalled.
// arst_n clears all valid flags, the held pulse to 1500, the sequence to idle and
// the configuration to its defaults. a stall on m_axis holds the pipeline; stages
// left empty still take new words.
`timescale 1ns / 1ps
`default_nettype none

module esc_pulse_ramp_sequencer (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire  [15:0]                            s_axis_tdata,  // speed[11:0], pad
	input  wire  [esc_prs_pkg::REQ_W-1:0]          s_axis_tuser,  // req_type[1:0]
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	output logic [15:0]                            m_axis_tdata,  // pulse_width, busy, accepted
	input  wire                                    cfg_we,
	input  wire  [esc_prs_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire  [esc_prs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	esc_prs_pkg::cfg_t      cfg;
	esc_prs_pkg::tgt_word_t tgt_word;
	logic                   tgt_valid;
	logic                   tgt_ready;
	logic [esc_prs_pkg::PW_W-1:0] pulse;
	logic                   busy;
	logic                   accepted;

	esc_prs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	esc_prs_target u_target (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_req    (s_axis_tuser),
		.in_speed  ($signed(s_axis_tdata[esc_prs_pkg::SPEED_W-1:0])),
		.out_valid (tgt_valid),
		.out_ready (tgt_ready),
		.out_word  (tgt_word)
	);

	esc_prs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (tgt_valid),
		.in_ready     (tgt_ready),
		.in_word      (tgt_word),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_pulse    (pulse),
		.out_busy     (busy),
		.out_accepted (accepted)
	);

	assign m_axis_tdata = {2'b00, accepted, busy, pulse};

endmodule

`default_nettype wire

/* dv/esc_pulse_ramp_sequencer_tb.sv */
// self-checking testbench for the esc pulse ramp sequencer
`timescale 1ns / 1ps

module esc_pulse_ramp_sequencer_tb;

	localparam int IDLE_LIMIT = 4000;
	localparam int SPEED_CAP  = 1000;
	localparam int SPEED_SPAN = 2000;
	localparam int BRAKE_DROP = 50;
	localparam int MAX_SHOWN  = 10;

	typedef enum logic [1:0] {
		SEQ_IDLE    = 2'd0,
		SEQ_NEUTRAL = 2'd1,
		SEQ_BRAKE   = 2'd2,
		SEQ_REENTRY = 2'd3
	} seq_phase_t;

	typedef struct packed {
		esc_prs_pkg::req_t req;
		logic [11:0]       speed;
		logic              drain;
	} esc_req_t;

	typedef struct packed {
		logic [esc_prs_pkg::PW_W-1:0] pw;
		logic                         busy;
		logic                         acc;
	} pulse_res_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [15:0]                          s_axis_tdata = '0;
	logic [esc_prs_pkg::REQ_W-1:0]        s_axis_tuser = '0;
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [15:0]                          m_axis_tdata;
	logic                                 cfg_we = 1'b0;
	logic [esc_prs_pkg::CFG_IDX_W-1:0]    cfg_addr = '0;
	logic [esc_prs_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

	esc_pulse_ramp_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block: registers and sequencer state
	esc_prs_pkg::cfg_t            regs;
	logic [esc_prs_pkg::PW_W-1:0] held_pw;
	seq_phase_t                   seq_phase;
	logic [15:0]                  tick_cnt;

	esc_req_t   pend_reqs[$];
	pulse_res_t pulses_due[$];

	int n_sent, n_checked, n_err, n_seq_done, n_ignored, n_queued;
	int tx_wait, tx_calm, rx_wait, rx_calm, idle_cycles;

	function automatic int bound_pulse(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [esc_prs_pkg::PW_W-1:0] pw_of(input int v);
		return v[esc_prs_pkg::PW_W-1:0];
	endfunction

	function automatic pulse_res_t advance_sequencer(input esc_prs_pkg::req_t rq,
		input logic [11:0] raw);
		int spd, tgt, nxt, held, fmin, fmax, step, flo, cei;
		pulse_res_t r;
		spd  = int'($signed(raw));
		held = int'(held_pw);
		fmin = int'(regs.fwd_min);
		fmax = int'(regs.fwd_max);
		step = int'(regs.ramp_step);
		flo  = int'(regs.floor_pw);
		cei  = int'(regs.ceil_pw);
		r.acc = 1'b1;
		if (rq == esc_prs_pkg::REQ_TICK) begin
			if (seq_phase != SEQ_IDLE) begin
				tick_cnt = tick_cnt + 16'd1;
				// a hold of zero behaves as one since the count is already past it
				if (tick_cnt >= regs.hold_ticks) begin
					tick_cnt = '0;
					case (seq_phase)
						SEQ_NEUTRAL: begin
							held_pw = pw_of(bound_pulse(fmin - BRAKE_DROP, flo, cei));
							seq_phase = SEQ_BRAKE;
						end
						SEQ_BRAKE: begin
							held_pw = pw_of(bound_pulse(int'(regs.neutral), flo, cei));
							seq_phase = SEQ_REENTRY;
						end
						default: begin
							held_pw = pw_of(bound_pulse(fmin, flo, cei));
							seq_phase = SEQ_IDLE;
							n_seq_done++;
						end
					endcase
				end
			end
		end else if (seq_phase != SEQ_IDLE) begin
			r.acc = 1'b0;
			n_ignored++;
		end else if (rq == esc_prs_pkg::REQ_FWD) begin
			if (spd < 0)
				spd = 0;
			if (spd > SPEED_CAP)
				spd = SPEED_CAP;
			tgt = fmin + ((spd + SPEED_CAP) * (fmax - fmin)) / SPEED_SPAN;
			tgt = bound_pulse(tgt, fmin, fmax);
			if (tgt > held) begin
				nxt = held + step;
				held_pw = pw_of(bound_pulse((nxt > tgt) ? tgt : nxt, flo, cei));
			end else if (tgt < held) begin
				// ramp down falls to the floor once the step would reach or pass zero
				nxt = (held > step) ? held - step : flo;
				held_pw = pw_of(bound_pulse((nxt < tgt) ? tgt : nxt, flo, cei));
			end
		end else if (rq == esc_prs_pkg::REQ_STOP) begin
			held_pw = pw_of(bound_pulse(int'(regs.neutral), flo, cei));
		end else begin
			held_pw = pw_of(bound_pulse(int'(regs.neutral), flo, cei));
			seq_phase = SEQ_NEUTRAL;
			tick_cnt = '0;
		end
		r.pw = held_pw;
		r.busy = (seq_phase != SEQ_IDLE);
		return r;
	endfunction

	// sender: one word at a time from the pending queue
	always @(posedge clk or negedge arst_n) begin : drv
		esc_req_t it;
		logic acc;
		int w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			tx_wait <= 0;
			tx_calm <= 0;
		end else begin
			acc = s_axis_tvalid && s_axis_tready;
			if (acc) begin
				pulses_due.push_back(advance_sequencer(s_axis_tuser, s_axis_tdata[11:0]));
				n_sent++;
			end
			if (!(s_axis_tvalid && !acc)) begin
				w = tx_wait;
				if (acc) begin
					if (tx_calm > 0) begin
						w = 0;
						tx_calm <= tx_calm - 1;
					end else begin
						w = $urandom_range(0, 12);
						if ($urandom_range(0, 29) == 0)
							tx_calm <= $urandom_range(10, 40);
					end
				end
				if (w > 0) begin
					s_axis_tvalid <= 1'b0;
					tx_wait <= w - 1;
				end else if (pend_reqs.size() > 0 &&
						(!pend_reqs[0].drain || pulses_due.size() == 0)) begin
					it = pend_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {4'b0000, it.speed};
					s_axis_tuser <= it.req;
					tx_wait <= 0;
				end else begin
					s_axis_tvalid <= 1'b0;
					tx_wait <= 0;
				end
			end
		end
	end

	// receiver: random stalls, each word checked against the oldest expected pulse
	always @(posedge clk or negedge arst_n) begin : mon
		pulse_res_t want, got;
		int w;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait <= 0;
			rx_calm <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			got = '{pw: m_axis_tdata[11:0], busy: m_axis_tdata[12], acc: m_axis_tdata[13]};
			if (pulses_due.size() == 0) begin
				n_err++;
				if (n_err <= MAX_SHOWN)
					$display("unexpected word: pw %0d busy %0b acc %0b",
						got.pw, got.busy, got.acc);
			end else begin
				want = pulses_due.pop_front();
				n_checked++;
				if (got.pw !== want.pw || got.busy !== want.busy || got.acc !== want.acc) begin
					n_err++;
					if (n_err <= MAX_SHOWN)
						$display("mismatch %0d: want pw %0d busy %0b acc %0b, %s",
							n_checked, want.pw, want.busy, want.acc,
							$sformatf("got pw %0d busy %0b acc %0b",
								got.pw, got.busy, got.acc));
				end
			end
			if (rx_calm > 0) begin
				w = 0;
				rx_calm <= rx_calm - 1;
			end else begin
				w = $urandom_range(0, 12);
				if ($urandom_range(0, 29) == 0)
					rx_calm <= $urandom_range(10, 40);
			end
			m_axis_tready <= (w == 0);
			rx_wait <= w;
		end else if (!m_axis_tready) begin
			if (rx_wait <= 1) begin
				m_axis_tready <= 1'b1;
				rx_wait <= 0;
			end else begin
				rx_wait <= rx_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles, %0d still expected",
					idle_cycles, pulses_due.size());
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic push_req(input esc_prs_pkg::req_t rq, input int spd, input bit drain = 1'b0);
		esc_req_t it;
		it.req = rq;
		it.speed = spd[11:0];
		it.drain = drain;
		pend_reqs.push_back(it);
		n_queued++;
	endtask

	function automatic int rand_speed();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 4095);
			1: begin
				case ($urandom_range(0, 5))
					0: return -2048;
					1: return 2047;
					2: return 0;
					3: return 1000;
					4: return -1;
					default: return 1001;
				endcase
			end
			2: return -$urandom_range(1, 2048);
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	// one burst of related words; with a short hold reverse entries get enough ticks to finish
	task automatic queue_episode();
		int n, ticks, hold;
		bit drain;
		drain = ($urandom_range(0, 14) == 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_req(esc_prs_pkg::REQ_FWD, rand_speed(), drain && i == 0);
			end
			4: push_req(esc_prs_pkg::REQ_STOP, rand_speed(), drain);
			5, 6, 7: begin
				hold = (regs.hold_ticks == '0) ? 1 : int'(regs.hold_ticks);
				ticks = (hold <= 8) ? 3 * hold + $urandom_range(0, 3) : $urandom_range(1, 6);
				push_req(esc_prs_pkg::REQ_BACK, rand_speed(), drain);
				for (int i = 0; i < ticks; i++) begin
					if ($urandom_range(0, 5) == 0)
						push_req(esc_prs_pkg::req_t'($urandom_range(0, 2)), rand_speed());
					push_req(esc_prs_pkg::REQ_TICK, rand_speed());
				end
			end
			8: push_req(esc_prs_pkg::req_t'($urandom_range(0, 3)), rand_speed(), drain);
			default: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					push_req(esc_prs_pkg::REQ_TICK, rand_speed(), drain && i == 0);
			end
		endcase
	endtask

	task automatic fill_random(input int goal);
		n_queued = 0;
		while (n_queued < goal)
			queue_episode();
	endtask

	// block idle: nothing pending, nothing in flight, pipeline drained
	task automatic wait_idle();
		while (pend_reqs.size() != 0 || s_axis_tvalid || pulses_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [esc_prs_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val[esc_prs_pkg::CFG_DATA_W-1:0];
		case (idx)
			esc_prs_pkg::CFG_RAMP_STEP: regs.ramp_step = val[esc_prs_pkg::STEP_W-1:0];
			esc_prs_pkg::CFG_NEUTRAL:   regs.neutral = val[esc_prs_pkg::PW_W-1:0];
			esc_prs_pkg::CFG_FWD_MIN:   regs.fwd_min = val[esc_prs_pkg::PW_W-1:0];
			esc_prs_pkg::CFG_FWD_MAX:   regs.fwd_max = val[esc_prs_pkg::PW_W-1:0];
			esc_prs_pkg::CFG_FLOOR:     regs.floor_pw = val[esc_prs_pkg::PW_W-1:0];
			esc_prs_pkg::CFG_CEILING:   regs.ceil_pw = val[esc_prs_pkg::PW_W-1:0];
			esc_prs_pkg::CFG_HOLD:      regs.hold_ticks = val[esc_prs_pkg::HOLD_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_settings(input int unsigned step, input int unsigned neutral,
		input int unsigned fmin, input int unsigned fmax, input int unsigned flo,
		input int unsigned cei, input int unsigned hold);
		wait_idle();
		write_reg(esc_prs_pkg::CFG_RAMP_STEP, step);
		write_reg(esc_prs_pkg::CFG_NEUTRAL, neutral);
		write_reg(esc_prs_pkg::CFG_FWD_MIN, fmin);
		write_reg(esc_prs_pkg::CFG_FWD_MAX, fmax);
		write_reg(esc_prs_pkg::CFG_FLOOR, flo);
		write_reg(esc_prs_pkg::CFG_CEILING, cei);
		write_reg(esc_prs_pkg::CFG_HOLD, hold);
	endtask

	initial begin
		regs.ramp_step = esc_prs_pkg::RST_RAMP_STEP;
		regs.neutral = esc_prs_pkg::RST_NEUTRAL;
		regs.fwd_min = esc_prs_pkg::RST_FWD_MIN;
		regs.fwd_max = esc_prs_pkg::RST_FWD_MAX;
		regs.floor_pw = esc_prs_pkg::RST_FLOOR;
		regs.ceil_pw = esc_prs_pkg::RST_CEILING;
		regs.hold_ticks = esc_prs_pkg::RST_HOLD;
		held_pw = esc_prs_pkg::RST_NEUTRAL;
		seq_phase = SEQ_IDLE;
		tick_cnt = '0;
		n_sent = 0;
		n_checked = 0;
		n_err = 0;
		n_seq_done = 0;
		n_ignored = 0;
		n_queued = 0;
		idle_cycles = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: speed saturation both ways, stop, and requests dropped mid-sequence
		@(posedge clk);
		push_req(esc_prs_pkg::REQ_FWD, -2048);
		push_req(esc_prs_pkg::REQ_FWD, 2047);
		push_req(esc_prs_pkg::REQ_FWD, 1000);
		push_req(esc_prs_pkg::REQ_FWD, 1001);
		push_req(esc_prs_pkg::REQ_FWD, 0);
		push_req(esc_prs_pkg::REQ_FWD, -1);
		push_req(esc_prs_pkg::REQ_FWD, 500);
		push_req(esc_prs_pkg::REQ_STOP, 0);
		push_req(esc_prs_pkg::REQ_TICK, 2047);
		push_req(esc_prs_pkg::REQ_BACK, -2048);
		push_req(esc_prs_pkg::REQ_FWD, 1000);
		push_req(esc_prs_pkg::REQ_STOP, 0);
		push_req(esc_prs_pkg::REQ_BACK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0, 1'b1);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		fill_random(130);

		// widest limits, largest step, single-tick phases, brake landing on zero
		apply_settings(1023, 0, 50, 4095, 0, 4095, 1);
		push_req(esc_prs_pkg::REQ_FWD, 2047);
		push_req(esc_prs_pkg::REQ_BACK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		fill_random(130);

		// crossed limits everywhere, a step of one
		apply_settings(1, 4095, 4095, 0, 4095, 0, 2);
		fill_random(120);

		// zero step, zero hold, brake pulse below zero
		apply_settings(0, 1000, 10, 2000, 0, 4095, 0);
		push_req(esc_prs_pkg::REQ_BACK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		push_req(esc_prs_pkg::REQ_TICK, 0);
		push_req(esc_prs_pkg::REQ_FWD, 0);
		push_req(esc_prs_pkg::REQ_FWD, 1000);
		fill_random(120);

		// longest hold: the sequence cannot finish here
		apply_settings(37, 1520, 1250, 1800, 900, 2100, 65535);
		fill_random(60);

		repeat (4) begin
			if ($urandom_range(0, 1))
				apply_settings($urandom_range(1, 1023), $urandom_range(0, 4095),
					$urandom_range(50, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(1, 6));
			else
				apply_settings($urandom_range(1, 200), $urandom_range(1200, 1800),
					$urandom_range(1000, 1500), $urandom_range(1500, 2200),
					$urandom_range(0, 1200), $urandom_range(1800, 4095),
					$urandom_range(1, 4));
			fill_random(110);
		end

		wait_idle();
		$display("sent %0d requests and checked %0d pulse words over 9 register settings",
			n_sent, n_checked);
		$display("%0d reverse sequences completed, %0d requests dropped while busy",
			n_seq_done, n_ignored);
		if (n_err == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatching words", n_err);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
